### rtl/image_mean_color_alpha_assert.svh
// Assertion macros for the image mean color block.
`ifndef IMAGE_MEAN_COLOR_ALPHA_ASSERT_SVH
`define IMAGE_MEAN_COLOR_ALPHA_ASSERT_SVH

`ifndef ASSERT_OFF
// Same-cycle implication, sampled on clk, off while arst_n is low.
`define IMCA_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("imca: same-cycle check failed");
// Next-cycle implication, sampled on clk, off while arst_n is low.
`define IMCA_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("imca: next-cycle check failed");
`else
`define IMCA_ASSERT_IMP(lbl, ante, cons)
`define IMCA_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

### rtl/imca_pkg.sv
// Shared types, codes and helpers of the image mean color block.
`timescale 1ns / 1ps
`default_nettype none

package imca_pkg;

	localparam logic [7:0] CHAN_MAX = 8'd255;

	// register indexes
	localparam logic [1:0] REG_MODE     = 2'd0;
	localparam logic [1:0] REG_BG_RED   = 2'd1;
	localparam logic [1:0] REG_BG_GREEN = 2'd2;
	localparam logic [1:0] REG_BG_BLUE  = 2'd3;

	// mode register codes; the unused code acts as plain
	localparam logic [1:0] MODE_PLAIN     = 2'd0;
	localparam logic [1:0] MODE_SKIP      = 2'd1;
	localparam logic [1:0] MODE_COMPOSITE = 2'd2;

	typedef enum logic [1:0] {
		KIND_PLAIN,
		KIND_SKIP,
		KIND_COMPOSITE
	} kind_t;

	typedef struct packed {
		kind_t kind;
		logic  saturated;
	} img_info_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_LOAD,
		BK_CHECK,
		BK_STEP,
		BK_HOLD
	} bk_state_t;

	// width of one closed image record: three color sums, alpha sum, two counts, info
	function automatic int img_bits(input int cb);
		return 3 * (cb + 16) + (cb + 8) + 2 * (cb + 1) + $bits(img_info_t);
	endfunction

endpackage

`default_nettype wire

### rtl/imca_fifo.sv
// Two-entry queue of closed image records between front and back.
`timescale 1ns / 1ps
`default_nettype none

module imca_fifo import imca_pkg::*; #(
	parameter int W = 205
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] push_data,
	input  logic         pop,
	output logic [W-1:0] head,
	output q_stat_t      q_stat
);

	// depth must stay a power of two so the pointers wrap by themselves
	localparam int DEPTH = 2;
	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [W-1:0]     mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			if (pop)
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			if (push && !pop)
				cnt_q <= cnt_q + CNT_W'(1);
			else if (pop && !push)
				cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_data;
	end

	assign head         = mem_q[rd_ptr_q];
	assign q_stat.full  = (cnt_q == CNT_W'(DEPTH));
	assign q_stat.empty = (cnt_q == '0);

endmodule

`default_nettype wire

### rtl/imca_front.sv
// Front end: takes pixels, classifies them by mode and accumulates the image sums.
`timescale 1ns / 1ps
`default_nettype none

module imca_front import imca_pkg::*; #(
	parameter int COUNT_BITS = 24
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             pix_valid,
	output logic                             pix_stall,
	input  logic [7:0]                       red,
	input  logic [7:0]                       green,
	input  logic [7:0]                       blue,
	input  logic [7:0]                       alpha,
	input  logic                             last,
	input  logic [1:0]                       mode,
	input  logic [7:0]                       bg_red,
	input  logic [7:0]                       bg_green,
	input  logic [7:0]                       bg_blue,
	input  q_stat_t                          q_stat,
	output logic                             push,
	output logic [img_bits(COUNT_BITS)-1:0]  push_data
);

	localparam int SUM_W = COUNT_BITS + 16;
	localparam int AS_W  = COUNT_BITS + 8;
	localparam int CNT_W = COUNT_BITS + 1;

	function automatic logic [15:0] blend(input logic [7:0] p, input logic [7:0] a,
			input logic [7:0] bg);
		logic [7:0] inv;
		inv = CHAN_MAX - a;
		return {8'd0, p} * {8'd0, a} + {8'd0, bg} * {8'd0, inv};
	endfunction

	kind_t       kind_c;
	logic [15:0] add_r_c, add_g_c, add_b_c;
	logic [7:0]  add_a_c;
	logic        keep_c;

	logic        v_s1;
	logic        last_s1;
	kind_t       kind_s1;
	logic [15:0] add_r_s1, add_g_s1, add_b_s1;
	logic [7:0]  add_a_s1;
	logic        keep_s1;

	logic [SUM_W-1:0] sum_r_q, sum_g_q, sum_b_q;
	logic [AS_W-1:0]  sum_a_q;
	logic [CNT_W-1:0] cnt_q, kept_q;
	logic             sat_q;

	logic [SUM_W-1:0] sum_r_d, sum_g_d, sum_b_d;
	logic [AS_W-1:0]  sum_a_d;
	logic [CNT_W-1:0] cnt_d, kept_d;
	logic             sat_d;
	logic             sat_hit;
	logic             accept;
	logic             consume;
	img_info_t        info;

	// classify the pixel by the mode in force now
	always_comb begin
		unique case (mode)
			MODE_SKIP:      kind_c = KIND_SKIP;
			MODE_COMPOSITE: kind_c = KIND_COMPOSITE;
			default:        kind_c = KIND_PLAIN;
		endcase
	end

	always_comb begin
		add_r_c = {8'd0, red};
		add_g_c = {8'd0, green};
		add_b_c = {8'd0, blue};
		add_a_c = 8'd0;
		keep_c  = 1'b0;
		unique case (kind_c)
			KIND_SKIP: begin
				keep_c = (alpha != 8'd0);
				if (!keep_c) begin
					add_r_c = '0;
					add_g_c = '0;
					add_b_c = '0;
				end
			end
			KIND_COMPOSITE: begin
				add_r_c = blend(red, alpha, bg_red);
				add_g_c = blend(green, alpha, bg_green);
				add_b_c = blend(blue, alpha, bg_blue);
			end
			default: add_a_c = alpha;
		endcase
	end

	// hold only a closing pixel that finds the queue full
	assign pix_stall = v_s1 && last_s1 && q_stat.full;
	assign accept    = pix_valid && !pix_stall;
	assign consume   = v_s1 && !pix_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s1 <= 1'b0;
		else if (!pix_stall)
			v_s1 <= pix_valid;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			last_s1  <= last;
			kind_s1  <= kind_c;
			add_r_s1 <= add_r_c;
			add_g_s1 <= add_g_c;
			add_b_s1 <= add_b_c;
			add_a_s1 <= add_a_c;
			keep_s1  <= keep_c;
		end
	end

	// count reaching 2^COUNT_BITS freezes the image sums
	assign sat_hit = cnt_q[COUNT_BITS];

	always_comb begin
		sum_r_d = sum_r_q;
		sum_g_d = sum_g_q;
		sum_b_d = sum_b_q;
		sum_a_d = sum_a_q;
		cnt_d   = cnt_q;
		kept_d  = kept_q;
		sat_d   = sat_q | sat_hit;
		if (!sat_hit) begin
			sum_r_d = sum_r_q + SUM_W'(add_r_s1);
			sum_g_d = sum_g_q + SUM_W'(add_g_s1);
			sum_b_d = sum_b_q + SUM_W'(add_b_s1);
			sum_a_d = sum_a_q + AS_W'(add_a_s1);
			cnt_d   = cnt_q + CNT_W'(1);
			kept_d  = kept_q + CNT_W'(keep_s1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_r_q <= '0;
			sum_g_q <= '0;
			sum_b_q <= '0;
			sum_a_q <= '0;
			cnt_q   <= '0;
			kept_q  <= '0;
			sat_q   <= 1'b0;
		end else if (consume) begin
			if (last_s1) begin
				sum_r_q <= '0;
				sum_g_q <= '0;
				sum_b_q <= '0;
				sum_a_q <= '0;
				cnt_q   <= '0;
				kept_q  <= '0;
				sat_q   <= 1'b0;
			end else begin
				sum_r_q <= sum_r_d;
				sum_g_q <= sum_g_d;
				sum_b_q <= sum_b_d;
				sum_a_q <= sum_a_d;
				cnt_q   <= cnt_d;
				kept_q  <= kept_d;
				sat_q   <= sat_d;
			end
		end
	end

	assign info.kind      = kind_s1;
	assign info.saturated = sat_d;
	assign push           = consume && last_s1;
	assign push_data      = {info, sum_r_d, sum_g_d, sum_b_d, sum_a_d, cnt_d, kept_d};

endmodule

`default_nettype wire

### rtl/imca_back.sv
// Back end: divides the closed image sums into clamped means, one quotient bit a cycle.
`timescale 1ns / 1ps
`default_nettype none

module imca_back import imca_pkg::*; #(
	parameter int COUNT_BITS = 24
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic [img_bits(COUNT_BITS)-1:0]  head,
	input  q_stat_t                          q_stat,
	output logic                             pop,
	output logic                             res_valid,
	input  logic                             res_stall,
	output logic [7:0]                       mean_red,
	output logic [7:0]                       mean_green,
	output logic [7:0]                       mean_blue,
	output logic [7:0]                       mean_alpha,
	output logic                             found,
	output logic                             overflow
);

	localparam int SUM_W = COUNT_BITS + 16;
	localparam int AS_W  = COUNT_BITS + 8;
	localparam int CNT_W = COUNT_BITS + 1;
	localparam int DEN_W = CNT_W + 8;
	localparam int CMP_W = DEN_W + 8;

	localparam logic [1:0] CH_RED   = 2'd0;
	localparam logic [1:0] CH_GREEN = 2'd1;
	localparam logic [1:0] CH_BLUE  = 2'd2;
	localparam logic [1:0] CH_ALPHA = 2'd3;

	img_info_t        info;
	logic [SUM_W-1:0] sum_r, sum_g, sum_b;
	logic [AS_W-1:0]  sum_a;
	logic [CNT_W-1:0] cnt, kept;

	bk_state_t        state_q, state_d;
	logic [1:0]       ch_q;
	logic [2:0]       step_q;
	logic [CMP_W-1:0] rem_q, dsh_q;
	logic [7:0]       quo_q, quo_d;
	logic [7:0]       res_q [4];
	logic             res_valid_q;

	logic [SUM_W-1:0] sum_sel;
	logic [DEN_W-1:0] den_sel;
	logic             ge;
	logic             last_ch;
	logic             start, load_en, shift_en, sub_en, step_en, store_en, out_load;
	logic [7:0]       store_val;

	assign {info, sum_r, sum_g, sum_b, sum_a, cnt, kept} = head;

	always_comb begin
		unique case (ch_q)
			CH_RED:   sum_sel = sum_r;
			CH_GREEN: sum_sel = sum_g;
			CH_BLUE:  sum_sel = sum_b;
			CH_ALPHA: sum_sel = SUM_W'(sum_a);
		endcase
	end

	// divisor: kept pixels when skipping, 255 per pixel when composited, else all pixels; zero for alpha unless plain
	always_comb begin
		unique case (info.kind)
			KIND_SKIP:      den_sel = DEN_W'(kept);
			KIND_COMPOSITE: den_sel = {cnt, 8'd0} - DEN_W'(cnt);
			default:        den_sel = DEN_W'(cnt);
		endcase
		if (ch_q == CH_ALPHA && info.kind != KIND_PLAIN)
			den_sel = '0;
	end

	assign ge      = (rem_q >= dsh_q);
	assign quo_d   = {quo_q[6:0], ge};
	assign last_ch = (ch_q == CH_ALPHA);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= BK_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d   = state_q;
		start     = 1'b0;
		load_en   = 1'b0;
		shift_en  = 1'b0;
		sub_en    = 1'b0;
		step_en   = 1'b0;
		store_en  = 1'b0;
		store_val = '0;
		out_load  = 1'b0;
		pop       = 1'b0;
		unique case (state_q)
			BK_IDLE: begin
				if (!q_stat.empty) begin
					start   = 1'b1;
					state_d = BK_LOAD;
				end
			end
			BK_LOAD: begin
				load_en = 1'b1;
				state_d = BK_CHECK;
			end
			BK_CHECK: begin
				// zero divisor gives zero; a quotient past 255 clamps at once
				if (dsh_q == '0) begin
					store_en = 1'b1;
				end else if (ge) begin
					store_en  = 1'b1;
					store_val = CHAN_MAX;
				end else begin
					shift_en = 1'b1;
					state_d  = BK_STEP;
				end
				if (store_en)
					state_d = last_ch ? BK_HOLD : BK_LOAD;
			end
			BK_STEP: begin
				shift_en = 1'b1;
				sub_en   = ge;
				step_en  = 1'b1;
				if (step_q == 3'd7) begin
					store_en  = 1'b1;
					store_val = quo_d;
					state_d   = last_ch ? BK_HOLD : BK_LOAD;
				end
			end
			BK_HOLD: begin
				if (!res_valid_q || !res_stall) begin
					out_load = 1'b1;
					pop      = 1'b1;
					state_d  = BK_IDLE;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ch_q   <= CH_RED;
			step_q <= '0;
		end else begin
			if (start)
				ch_q <= CH_RED;
			else if (store_en)
				ch_q <= ch_q + 2'd1;
			if (load_en)
				step_q <= '0;
			else if (step_en)
				step_q <= step_q + 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load_en) begin
			rem_q <= CMP_W'(sum_sel);
			dsh_q <= {den_sel, 8'd0};
			quo_q <= '0;
		end else begin
			if (shift_en)
				dsh_q <= dsh_q >> 1;
			if (sub_en)
				rem_q <= rem_q - dsh_q;
			if (step_en)
				quo_q <= quo_d;
		end
		if (store_en)
			res_q[ch_q] <= store_val;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			res_valid_q <= 1'b0;
		else if (out_load)
			res_valid_q <= 1'b1;
		else if (!res_stall)
			res_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			mean_red   <= res_q[CH_RED];
			mean_green <= res_q[CH_GREEN];
			mean_blue  <= res_q[CH_BLUE];
			mean_alpha <= res_q[CH_ALPHA];
			found      <= (info.kind != KIND_SKIP) || (kept != '0);
			overflow   <= info.saturated;
		end
	end

	assign res_valid = res_valid_q;

endmodule

`default_nettype wire

### rtl/image_mean_color_alpha.sv
// Top level of the streaming RGBA mean color block.
//
//  channel  direction  handshake            payload
//  pix      in         pix_valid/pix_stall  red green blue alpha last
//  res      out        res_valid/res_stall  mean_red mean_green mean_blue mean_alpha
//                                           found overflow
//  cfg      in         wr_en                wr_index wr_data
//
// Pixels enter at one per cycle while pix_stall is low; a result passes the front stage
// and the queue, then the back forms four means in turn (load, range check, eight quotient
// bits; only load and range check if the divisor is zero or the mean clamps) and registers
// them at the output. A back still busy with earlier images lets short images fill the
// two-entry queue; pix_stall rises when a last pixel meets it full. arst_n clears the
// control state and sums; res_stall holds the result and, once the queue fills, the input.
`timescale 1ns / 1ps
`default_nettype none
`include "image_mean_color_alpha_assert.svh"

module image_mean_color_alpha import imca_pkg::*; #(
	parameter int COUNT_BITS = 24
) (
	input  logic       clk,
	input  logic       arst_n,
	// pixel requests
	input  logic       pix_valid,
	output logic       pix_stall,
	input  logic [7:0] red,
	input  logic [7:0] green,
	input  logic [7:0] blue,
	input  logic [7:0] alpha,
	input  logic       last,
	// result requests
	output logic       res_valid,
	input  logic       res_stall,
	output logic [7:0] mean_red,
	output logic [7:0] mean_green,
	output logic [7:0] mean_blue,
	output logic [7:0] mean_alpha,
	output logic       found,
	output logic       overflow,
	// register writes
	input  logic       wr_en,
	input  logic [1:0] wr_index,
	input  logic [7:0] wr_data
);

	localparam int IMG_W = img_bits(COUNT_BITS);

	logic [1:0]       mode_q;
	logic [7:0]       bg_red_q, bg_green_q, bg_blue_q;
	logic             push, pop;
	logic [IMG_W-1:0] push_data, head;
	q_stat_t          q_stat;

	// config registers; the user must write them only while the block is idle, the block does not enforce it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= MODE_PLAIN;
			bg_red_q   <= '0;
			bg_green_q <= '0;
			bg_blue_q  <= '0;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_MODE:     mode_q     <= wr_data[1:0];
				REG_BG_RED:   bg_red_q   <= wr_data;
				REG_BG_GREEN: bg_green_q <= wr_data;
				REG_BG_BLUE:  bg_blue_q  <= wr_data;
			endcase
		end
	end

	// front: classify pixels and accumulate, push a record per image
	imca_front #(
		.COUNT_BITS(COUNT_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.pix_valid (pix_valid),
		.pix_stall (pix_stall),
		.red       (red),
		.green     (green),
		.blue      (blue),
		.alpha     (alpha),
		.last      (last),
		.mode      (mode_q),
		.bg_red    (bg_red_q),
		.bg_green  (bg_green_q),
		.bg_blue   (bg_blue_q),
		.q_stat    (q_stat),
		.push      (push),
		.push_data (push_data)
	);

	// queue: decouple pixel intake from the divider
	imca_fifo #(
		.W(IMG_W)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.head      (head),
		.q_stat    (q_stat)
	);

	// back: divide sums into means, drop the record once the result is loaded
	imca_back #(
		.COUNT_BITS(COUNT_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.q_stat     (q_stat),
		.pop        (pop),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.mean_red   (mean_red),
		.mean_green (mean_green),
		.mean_blue  (mean_blue),
		.mean_alpha (mean_alpha),
		.found      (found),
		.overflow   (overflow)
	);

	// input backpressure comes only from a full queue
	`IMCA_ASSERT_IMP(a_stall_needs_full, pix_stall, q_stat.full)
	// an empty result carries no color
	`IMCA_ASSERT_IMP(a_not_found_black, res_valid && !found,
		mean_red == 8'd0 && mean_green == 8'd0 && mean_blue == 8'd0 && mean_alpha == 8'd0)
	// one push a cycle: the queue cannot go from empty to full at once
	`IMCA_ASSERT_NXT(a_queue_fills_by_one, q_stat.empty, !q_stat.full)

endmodule

`default_nettype wire

### tb/tb.sv
// Self-checking testbench for the streaming RGBA mean color block.
`timescale 1ns / 1ps

module tb;
	import imca_pkg::*;

	// Pixel counter width as the block is built by default.
	localparam int CNT_BITS = 24;
	localparam logic [CNT_BITS:0] COUNT_LIMIT = {1'b1, {CNT_BITS{1'b0}}};
	localparam int LONG_LEN = 256;       // base length of the few long images
	localparam logic [1:0] MODE_SPARE = 2'd3; // unused code, acts as plain
	localparam int HALF_PERIOD = 2;
	localparam int RESET_CYCLES = 7;
	localparam int SETTLE = 64;
	localparam int WATCHDOG = 4000;      // cycles without any accepted request
	localparam int PHASES = 8;
	localparam int SMALL_PER_PHASE = 75;
	localparam int HOLD_AFTER = 30;      // pixels accepted before the long hold-off
	localparam int HOLD_CYCLES = 300;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] alpha;
		logic       last;
	} pixel_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] alpha;
		logic       found;
		logic       overflow;
	} mean_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       pix_valid = 1'b0;
	logic       pix_stall;
	logic [7:0] red = '0;
	logic [7:0] green = '0;
	logic [7:0] blue = '0;
	logic [7:0] alpha = '0;
	logic       last = 1'b0;
	logic       res_valid;
	logic       res_stall = 1'b0;
	logic [7:0] mean_red;
	logic [7:0] mean_green;
	logic [7:0] mean_blue;
	logic [7:0] mean_alpha;
	logic       found;
	logic       overflow;
	logic       wr_en = 1'b0;
	logic [1:0] wr_index = '0;
	logic [7:0] wr_data = '0;

	// Pixels waiting to be offered, and image means still owed by the block.
	pixel_t pending_pixels[$];
	mean_t  expected_means[$];
	pixel_t cur_pix;
	mean_t  got;
	int     pix_pushed = 0;
	int     pix_accepted = 0;
	int     failures = 0;
	int     gap_left = 0;
	int     stall_left = 0;
	int     hold_left = 0;
	bit     hold_done = 1'b0;
	bit     no_idle = 1'b0;
	int     quiet_cycles = 0;

	// Register copies and the open image's accumulators.
	logic [1:0]           cfg_mode = MODE_PLAIN;
	logic [7:0]           cfg_bg_red = '0;
	logic [7:0]           cfg_bg_green = '0;
	logic [7:0]           cfg_bg_blue = '0;
	logic [CNT_BITS+15:0] acc_red = '0;
	logic [CNT_BITS+15:0] acc_green = '0;
	logic [CNT_BITS+15:0] acc_blue = '0;
	logic [CNT_BITS+7:0]  acc_alpha = '0;
	logic [CNT_BITS:0]    img_pixels = '0;
	logic [CNT_BITS:0]    img_kept = '0;
	logic                 img_sat = 1'b0;

	image_mean_color_alpha #(
		.COUNT_BITS(CNT_BITS)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.pix_valid(pix_valid),
		.pix_stall(pix_stall),
		.red(red),
		.green(green),
		.blue(blue),
		.alpha(alpha),
		.last(last),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.mean_red(mean_red),
		.mean_green(mean_green),
		.mean_blue(mean_blue),
		.mean_alpha(mean_alpha),
		.found(found),
		.overflow(overflow),
		.wr_en(wr_en),
		.wr_index(wr_index),
		.wr_data(wr_data)
	);

	always #(HALF_PERIOD) clk = ~clk;

	// Blend one channel over the background, scaled by 255 (division deferred).
	function automatic logic [15:0] blend(input logic [7:0] pix, input logic [7:0] a,
		input logic [7:0] bg);
		return 16'(pix) * 16'(a) + 16'(bg) * (16'(CHAN_MAX) - 16'(a));
	endfunction

	// Truncated quotient, clamped to a channel; an empty denominator gives 0.
	function automatic logic [7:0] mean_clamp(input longint unsigned total,
		input longint unsigned denom);
		longint unsigned q;
		if (denom == 0)
			return 8'd0;
		q = total / denom;
		return (q > CHAN_MAX) ? CHAN_MAX : q[7:0];
	endfunction

	// Fold one accepted pixel into the open image; a closing pixel queues its means.
	function automatic void accumulate_pixel(input pixel_t p);
		mean_t m;
		if (img_pixels >= COUNT_LIMIT) begin
			img_sat = 1'b1;
		end else begin
			img_pixels++;
			case (cfg_mode)
			MODE_SKIP: begin
				if (p.alpha != 0) begin
					acc_red += p.red;
					acc_green += p.green;
					acc_blue += p.blue;
					img_kept++;
				end
			end
			MODE_COMPOSITE: begin
				acc_red += blend(p.red, p.alpha, cfg_bg_red);
				acc_green += blend(p.green, p.alpha, cfg_bg_green);
				acc_blue += blend(p.blue, p.alpha, cfg_bg_blue);
			end
			default: begin
				acc_red += p.red;
				acc_green += p.green;
				acc_blue += p.blue;
				acc_alpha += p.alpha;
			end
			endcase
		end
		if (!p.last)
			return;
		// The mode in force at the closing pixel decides how the means are formed.
		m = '0;
		m.found = 1'b1;
		case (cfg_mode)
		MODE_SKIP: begin
			m.red = mean_clamp(acc_red, img_kept);
			m.green = mean_clamp(acc_green, img_kept);
			m.blue = mean_clamp(acc_blue, img_kept);
			m.found = (img_kept != 0);
		end
		MODE_COMPOSITE: begin
			m.red = mean_clamp(acc_red, 255 * longint'(img_pixels));
			m.green = mean_clamp(acc_green, 255 * longint'(img_pixels));
			m.blue = mean_clamp(acc_blue, 255 * longint'(img_pixels));
		end
		default: begin
			m.red = mean_clamp(acc_red, img_pixels);
			m.green = mean_clamp(acc_green, img_pixels);
			m.blue = mean_clamp(acc_blue, img_pixels);
			m.alpha = mean_clamp(acc_alpha, img_pixels);
		end
		endcase
		m.overflow = img_sat;
		expected_means.push_back(m);
		acc_red = '0;
		acc_green = '0;
		acc_blue = '0;
		acc_alpha = '0;
		img_pixels = '0;
		img_kept = '0;
		img_sat = 1'b0;
	endfunction

	// Mostly back to back, often a short pause, now and then a long one.
	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 60)
			return 0;
		else if (roll < 90)
			return $urandom_range(1, 3);
		else if (roll < 98)
			return $urandom_range(4, 12);
		else
			return $urandom_range(20, 60);
	endfunction

	function automatic logic [7:0] chan_value();
		case ($urandom_range(0, 7))
		0: return 8'h00;
		1: return 8'hFF;
		default: return 8'($urandom);
		endcase
	endfunction

	// Lean on fully transparent pixels so that skip mode often drops some or all.
	function automatic logic [7:0] alpha_value();
		case ($urandom_range(0, 7))
		0, 1: return 8'h00;
		2: return 8'hFF;
		default: return 8'($urandom);
		endcase
	endfunction

	function automatic logic [7:0] bg_value();
		case ($urandom_range(0, 2))
		0: return 8'h00;
		1: return 8'hFF;
		default: return 8'($urandom);
		endcase
	endfunction

	task automatic push_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
		input logic [7:0] a, input logic l);
		pending_pixels.push_back('{red: r, green: g, blue: b, alpha: a, last: l});
		pix_pushed++;
	endtask

	// Queue one image of random pixels; leave it open when close is low.
	task automatic add_image(input int len, input bit close);
		for (int i = 0; i < len; i++)
			push_pixel(chan_value(), chan_value(), chan_value(), alpha_value(),
				close && (i == len - 1));
	endtask

	// Write one register and mirror it; callers write only after drain().
	task automatic set_reg(input logic [1:0] idx, input logic [7:0] data);
		@(posedge clk);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= data;
		case (idx)
		REG_MODE:     cfg_mode = data[1:0];
		REG_BG_RED:   cfg_bg_red = data;
		REG_BG_GREEN: cfg_bg_green = data;
		REG_BG_BLUE:  cfg_bg_blue = data;
		endcase
	endtask

	task automatic close_writes();
		@(posedge clk);
		wr_en <= 1'b0;
	endtask

	// Wait for every pixel to go in and every owed result to come out, then let
	// the block settle on any open image before the next register write.
	task automatic drain();
		while (pix_accepted != pix_pushed || expected_means.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// Pixel driver: advance on acceptance, hold the payload while stalled.
	always @(posedge clk) begin
		if (arst_n) begin
			if (pix_valid && !pix_stall) begin
				accumulate_pixel(cur_pix);
				pix_accepted++;
			end
			if (!pix_valid || !pix_stall) begin
				if (gap_left > 0) begin
					gap_left--;
					pix_valid <= 1'b0;
				end else if (pending_pixels.size() > 0) begin
					cur_pix = pending_pixels.pop_front();
					red <= cur_pix.red;
					green <= cur_pix.green;
					blue <= cur_pix.blue;
					alpha <= cur_pix.alpha;
					last <= cur_pix.last;
					pix_valid <= 1'b1;
					gap_left = no_idle ? 0 : pick_gap();
				end else begin
					pix_valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor: check each accepted result against the oldest owed image,
	// and drive random stalls plus one long hold-off to back the block up.
	always @(posedge clk) begin
		if (arst_n) begin
			if (res_valid && !res_stall) begin
				got = '{red: mean_red, green: mean_green, blue: mean_blue, alpha: mean_alpha,
					found: found, overflow: overflow};
				if (expected_means.size() == 0) begin
					failures++;
					if (failures <= 10)
						$display(
							"%0t: result with no image pending: r=%0d g=%0d b=%0d a=%0d f=%0d o=%0d",
							$realtime, got.red, got.green, got.blue, got.alpha, got.found,
							got.overflow);
				end else begin
					mean_t want;
					string exp_s;
					want = expected_means.pop_front();
					if (got.red !== want.red || got.green !== want.green ||
						got.blue !== want.blue || got.alpha !== want.alpha ||
						got.found !== want.found || got.overflow !== want.overflow) begin
						failures++;
						if (failures <= 10) begin
							exp_s = $sformatf("r=%0d g=%0d b=%0d a=%0d f=%0d o=%0d",
								want.red, want.green, want.blue, want.alpha,
								want.found, want.overflow);
							$display("%0t: mean mismatch: expected %s, got %s",
								$realtime, exp_s,
								$sformatf("r=%0d g=%0d b=%0d a=%0d f=%0d o=%0d",
									got.red, got.green, got.blue, got.alpha,
									got.found, got.overflow));
						end
					end
				end
			end
			if (!hold_done && pix_accepted >= HOLD_AFTER) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				res_stall <= 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				res_stall <= 1'b1;
			end else begin
				stall_left = no_idle ? 0 : pick_gap();
				res_stall <= 1'b0;
			end
		end
	end

	// Watchdog: give up when no request moves on either channel for too long.
	always @(posedge clk) begin
		if (!arst_n || (pix_valid && !pix_stall) || (res_valid && !res_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG) begin
			$display("Verification failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		int         phase;
		int         sent;
		int         len;
		int         long_len;
		int         roll;
		logic [1:0] next_mode;

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Plain mode from reset: all-white, all-black, and a two-pixel average.
		push_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1);
		push_pixel(8'h00, 8'h00, 8'h00, 8'h00, 1'b1);
		push_pixel(8'hFF, 8'h00, 8'hFF, 8'h00, 1'b0);
		push_pixel(8'h00, 8'hFF, 8'h00, 8'hFF, 1'b1);
		drain();

		// Skip mode: an image with no opaque pixel, then one with a single faint one.
		set_reg(REG_MODE, MODE_SKIP);
		close_writes();
		push_pixel(8'd9, 8'd9, 8'd9, 8'h00, 1'b0);
		push_pixel(8'd200, 8'd200, 8'd200, 8'h00, 1'b1);
		push_pixel(8'hFF, 8'hFF, 8'hFF, 8'h00, 1'b0);
		push_pixel(8'd10, 8'd20, 8'd30, 8'h01, 1'b1);
		drain();

		// Composite over a background of extreme and middle values: transparent, opaque, then a mix.
		set_reg(REG_MODE, MODE_COMPOSITE);
		set_reg(REG_BG_RED, 8'hFF);
		set_reg(REG_BG_GREEN, 8'h00);
		set_reg(REG_BG_BLUE, 8'd128);
		close_writes();
		push_pixel(8'h00, 8'hFF, 8'd7, 8'h00, 1'b1);
		push_pixel(8'd1, 8'd2, 8'd3, 8'hFF, 1'b1);
		push_pixel(8'd100, 8'd50, 8'd200, 8'd128, 1'b0);
		push_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0);
		push_pixel(8'h00, 8'h00, 8'h00, 8'd64, 1'b1);
		// Leave an image open in composite mode to be closed as plain: the scaled
		// sums then exceed a channel and the means must clamp.
		push_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0);
		drain();

		// Unused mode code closes the image as plain, then starts another one.
		set_reg(REG_MODE, MODE_SPARE);
		close_writes();
		push_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1);
		push_pixel(8'd17, 8'd34, 8'd51, 8'd68, 1'b0);
		push_pixel(8'd3, 8'd5, 8'd7, 8'd9, 1'b1);
		push_pixel(8'd200, 8'd100, 8'd50, 8'h00, 1'b0);
		drain();

		// Mode change within an image: the open pixel was summed as plain.
		set_reg(REG_MODE, MODE_SKIP);
		close_writes();
		push_pixel(8'd40, 8'd80, 8'd120, 8'd77, 1'b1);
		drain();

		// Random phases: every mode with extreme and random backgrounds, mostly
		// short images, and a few long ones that keep the divider busy.
		for (phase = 0; phase < PHASES; phase++) begin
			no_idle = (phase % 4 == 3);
			next_mode = (phase < 4) ? 2'(phase) : 2'($urandom_range(0, 3));
			// Random upper bits on the mode write must be ignored.
			set_reg(REG_MODE, {6'($urandom), next_mode});
			set_reg(REG_BG_RED, bg_value());
			set_reg(REG_BG_GREEN, bg_value());
			set_reg(REG_BG_BLUE, bg_value());
			close_writes();
			case (phase)
			1: long_len = LONG_LEN + 1 + $urandom_range(0, 30);
			4: long_len = LONG_LEN;
			6: long_len = LONG_LEN + 1;
			default: long_len = 0;
			endcase
			sent = 0;
			while (sent < SMALL_PER_PHASE) begin
				roll = $urandom_range(0, 99);
				if (roll < 70)
					len = $urandom_range(1, 4);
				else if (roll < 95)
					len = $urandom_range(5, 16);
				else
					len = $urandom_range(17, 40);
				add_image(len, 1'b1);
				sent += len;
				if (long_len != 0 && sent >= 20) begin
					add_image(long_len, 1'b1);
					long_len = 0;
				end
			end
			// Sometimes carry an open image across the register change.
			if (phase != PHASES - 1 && $urandom_range(0, 2) == 0)
				add_image($urandom_range(1, 3), 1'b0);
			drain();
		end

		if (failures == 0 && expected_means.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
